// ===== rtl/q2e_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// shared types, constants and the cordic step for the quaternion to euler block
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int SUM_W        = 40;   // q.30 working width of sines, cosines and cordic
    localparam int REST_W       = 61;   // 1 - s^2 in q.60
    localparam int ROOT_BITS    = 31;   // floor sqrt of REST_W bits
    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 32;   // 2^32 is one full turn

    localparam logic signed [SUM_W-1:0] Q30_ONE = 40'sd1073741824;
    localparam logic [ANG_W-1:0] TURN_HALF          = 32'h8000_0000;
    localparam logic [ANG_W-1:0] TURN_QUARTER       = 32'h4000_0000;
    localparam logic [ANG_W-1:0] TURN_MINUS_QUARTER = 32'hC000_0000;

    // atan2 arguments after the half-turn prerotation
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic                    zero;
        logic                    flip;
    } q2e_vec_t;

    typedef struct packed {
        q2e_vec_t                roll;
        q2e_vec_t                yaw;
        logic signed [SUM_W-1:0] pitch_y;
        logic                    clamp_pos;
        logic                    clamp_neg;
    } q2e_cargo_t;

    typedef struct packed {
        q2e_cargo_t        cargo;
        logic [REST_W-1:0] rest;
    } q2e_job_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic [ANG_W-1:0]        ang;
    } q2e_rot_t;

    function automatic logic [ANG_W-1:0] arc_tan(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // one vectoring rotation, driving y toward zero
    function automatic q2e_rot_t cordic_step(input q2e_rot_t s, input logic [4:0] i);
        q2e_rot_t                r;
        logic signed [SUM_W-1:0] dx;
        logic signed [SUM_W-1:0] dy;
        dx = s.x >>> i;
        dy = s.y >>> i;
        r  = s;
        if (!s.y[SUM_W-1])
        begin
            r.x   = s.x + dy;
            r.y   = s.y - dx;
            r.ang = s.ang + arc_tan(i);
        end
        else
        begin
            r.x   = s.x - dy;
            r.y   = s.y + dx;
            r.ang = s.ang - arc_tan(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/q2e_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_front
// component products, sine and cosine terms, pitch clamp and atan2 prerotation
// ----------------------------------------------------------------------------
module q2e_front #(
    parameter int COMP_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COMP_BITS-1:0] comp_w,
    input  logic signed [COMP_BITS-1:0] comp_x,
    input  logic signed [COMP_BITS-1:0] comp_y,
    input  logic signed [COMP_BITS-1:0] comp_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output q2e_pkg::q2e_job_t           out_job
);
    import q2e_pkg::*;

    localparam int PROD_W = 2 * COMP_BITS;
    localparam int SH_L   = 2 * (32 - COMP_BITS);

    logic       adv;
    logic [2:0] vld_reg;

    logic signed [PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PROD_W-1:0] p_wy_reg, p_zx_reg, p_wz_reg, p_xy_reg;
    logic signed [SUM_W-1:0]  roll_s_reg, roll_c_reg, pitch_s_reg, yaw_s_reg, yaw_c_reg;
    q2e_job_t                 job_reg;
    q2e_job_t                 job_next;

    logic signed [30:0] pitch_n;
    logic signed [61:0] pitch_sq;
    logic [61:0]        rest_full;

    // product of raw components, floored to q.30
    function automatic logic signed [SUM_W-1:0] to_q30(input logic signed [PROD_W-1:0] p);
        logic signed [63:0] e;
        e = 64'(p);
        e = e <<< SH_L;
        e = e >>> 30;
        return e[SUM_W-1:0];
    endfunction

    function automatic q2e_vec_t prep(input logic signed [SUM_W-1:0] y,
                                      input logic signed [SUM_W-1:0] x);
        q2e_vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.flip = x[SUM_W-1];
        v.x    = x[SUM_W-1] ? -x : x;
        v.y    = x[SUM_W-1] ? -y : y;
        return v;
    endfunction

    assign adv       = !vld_reg[2] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[2];
    assign out_job   = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= comp_w * comp_x;
            p_yz_reg <= comp_y * comp_z;
            p_xx_reg <= comp_x * comp_x;
            p_yy_reg <= comp_y * comp_y;
            p_zz_reg <= comp_z * comp_z;
            p_wy_reg <= comp_w * comp_y;
            p_zx_reg <= comp_z * comp_x;
            p_wz_reg <= comp_w * comp_z;
            p_xy_reg <= comp_x * comp_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_s_reg  <= (to_q30(p_wx_reg) + to_q30(p_yz_reg)) <<< 1;
            roll_c_reg  <= Q30_ONE - ((to_q30(p_xx_reg) + to_q30(p_yy_reg)) <<< 1);
            pitch_s_reg <= (to_q30(p_wy_reg) - to_q30(p_zx_reg)) <<< 1;
            yaw_s_reg   <= (to_q30(p_wz_reg) + to_q30(p_xy_reg)) <<< 1;
            yaw_c_reg   <= Q30_ONE - ((to_q30(p_yy_reg) + to_q30(p_zz_reg)) <<< 1);
        end
    end

    // square only matters when the pitch sine is inside the open unit range
    always_comb
    begin
        pitch_n   = pitch_s_reg[30:0];
        pitch_sq  = pitch_n * pitch_n;
        rest_full = (62'd1 << 60) - $unsigned(pitch_sq);

        job_next.cargo.roll      = prep(roll_s_reg, roll_c_reg);
        job_next.cargo.yaw       = prep(yaw_s_reg, yaw_c_reg);
        job_next.cargo.pitch_y   = pitch_s_reg;
        job_next.cargo.clamp_pos = pitch_s_reg >= Q30_ONE;
        job_next.cargo.clamp_neg = pitch_s_reg <= -Q30_ONE;
        job_next.rest            = rest_full[REST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            job_reg <= job_next;
    end

`ifndef SYNTH
    a_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> !(job_reg.cargo.clamp_pos && job_reg.cargo.clamp_neg))
        else $error("pitch clamped both ways");
    a_rest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !job_reg.cargo.clamp_pos && !job_reg.cargo.clamp_neg)
        |-> (job_reg.rest != '0))
        else $error("pitch cosine term vanished inside unit range");
`endif

endmodule
`default_nettype wire

// ===== rtl/q2e_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_queue
// small register queue between the classifying front and the cordic back
// ----------------------------------------------------------------------------
module q2e_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/q2e_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_back
// pipelined square root for the pitch cosine, three cordic lanes, rounding
// ----------------------------------------------------------------------------
module q2e_back #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  q2e_pkg::q2e_job_t     in_job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ANGLE_BITS-1:0] roll_angle,
    output logic [ANGLE_BITS-1:0] pitch_angle,
    output logic [ANGLE_BITS-1:0] yaw_angle
);
    import q2e_pkg::*;

    localparam int LAST = CORDIC_STEPS - 1;

    logic adv;

    logic [ROOT_BITS-1:0] sq_vld_reg;
    logic [63:0]          sq_rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] sq_root_reg [ROOT_BITS];
    q2e_cargo_t           sq_cargo_reg [ROOT_BITS];

    logic [CORDIC_STEPS-1:0] cd_vld_reg;
    q2e_rot_t                cd_roll_reg  [CORDIC_STEPS];
    q2e_rot_t                cd_pitch_reg [CORDIC_STEPS];
    q2e_rot_t                cd_yaw_reg   [CORDIC_STEPS];
    logic [3:0]              cd_flag_reg  [CORDIC_STEPS];  // roll zero, yaw zero, clamps

    logic                  out_vld_reg;
    logic [ANGLE_BITS-1:0] roll_reg, pitch_reg, yaw_reg;
    logic [ANG_W-1:0]      roll_ang, pitch_ang, yaw_ang;
    logic [ANGLE_BITS-1:0] roll_rnd, pitch_rnd, yaw_rnd;

    assign adv         = !out_vld_reg || out_ready;
    assign in_ready    = adv;
    assign out_valid   = out_vld_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= '0;
            cd_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg  <= {sq_vld_reg[ROOT_BITS-2:0], in_valid};
            cd_vld_reg  <= {cd_vld_reg[CORDIC_STEPS-2:0], sq_vld_reg[ROOT_BITS-1]};
            out_vld_reg <= cd_vld_reg[LAST];
        end
    end

    // restoring square root, one root bit per stage from the top
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_sqrt
        localparam int B = ROOT_BITS - 1 - k;
        logic [63:0]          rem_in;
        logic [ROOT_BITS-1:0] root_in;
        q2e_cargo_t           cargo_in;
        logic [63:0]          trial;

        if (k == 0)
        begin : g_head
            assign rem_in   = 64'(in_job.rest);
            assign root_in  = '0;
            assign cargo_in = in_job.cargo;
        end
        else
        begin : g_body
            assign rem_in   = sq_rem_reg[k-1];
            assign root_in  = sq_root_reg[k-1];
            assign cargo_in = sq_cargo_reg[k-1];
        end

        assign trial = (64'(root_in) << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_cargo_reg[k] <= cargo_in;
                if (rem_in >= trial)
                begin
                    sq_rem_reg[k]  <= rem_in - trial;
                    sq_root_reg[k] <= root_in | (ROOT_BITS'(1) << B);
                end
                else
                begin
                    sq_rem_reg[k]  <= rem_in;
                    sq_root_reg[k] <= root_in;
                end
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        q2e_rot_t   roll_in, pitch_in, yaw_in;
        logic [3:0] flag_in;

        if (i == 0)
        begin : g_head
            q2e_cargo_t c;
            assign c          = sq_cargo_reg[ROOT_BITS-1];
            assign roll_in.x  = c.roll.x;
            assign roll_in.y  = c.roll.y;
            assign roll_in.ang = c.roll.flip ? TURN_HALF : '0;
            assign yaw_in.x   = c.yaw.x;
            assign yaw_in.y   = c.yaw.y;
            assign yaw_in.ang = c.yaw.flip ? TURN_HALF : '0;
            assign pitch_in.x = SUM_W'(sq_root_reg[ROOT_BITS-1]);
            assign pitch_in.y = c.pitch_y;
            assign pitch_in.ang = '0;
            assign flag_in    = {c.roll.zero, c.yaw.zero, c.clamp_pos, c.clamp_neg};
        end
        else
        begin : g_body
            assign roll_in  = cd_roll_reg[i-1];
            assign pitch_in = cd_pitch_reg[i-1];
            assign yaw_in   = cd_yaw_reg[i-1];
            assign flag_in  = cd_flag_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_roll_reg[i]  <= cordic_step(roll_in, 5'(i));
                cd_pitch_reg[i] <= cordic_step(pitch_in, 5'(i));
                cd_yaw_reg[i]   <= cordic_step(yaw_in, 5'(i));
                cd_flag_reg[i]  <= flag_in;
            end
        end
    end

    always_comb
    begin
        roll_ang  = cd_flag_reg[LAST][3] ? '0 : cd_roll_reg[LAST].ang;
        yaw_ang   = cd_flag_reg[LAST][2] ? '0 : cd_yaw_reg[LAST].ang;
        pitch_ang = cd_flag_reg[LAST][1] ? TURN_QUARTER :
                    cd_flag_reg[LAST][0] ? TURN_MINUS_QUARTER : cd_pitch_reg[LAST].ang;
    end

    // round half up to the output angle width, wrapping at a full turn
    if (ANGLE_BITS < ANG_W)
    begin : g_round
        localparam logic [ANG_W-1:0] HALF_LSB = ANG_W'(1) << (ANG_W - 1 - ANGLE_BITS);
        logic [ANG_W-1:0] roll_sum, pitch_sum, yaw_sum;
        assign roll_sum  = roll_ang + HALF_LSB;
        assign pitch_sum = pitch_ang + HALF_LSB;
        assign yaw_sum   = yaw_ang + HALF_LSB;
        assign roll_rnd  = roll_sum[ANG_W-1 -: ANGLE_BITS];
        assign pitch_rnd = pitch_sum[ANG_W-1 -: ANGLE_BITS];
        assign yaw_rnd   = yaw_sum[ANG_W-1 -: ANGLE_BITS];
    end
    else
    begin : g_full
        assign roll_rnd  = roll_ang;
        assign pitch_rnd = pitch_ang;
        assign yaw_rnd   = yaw_ang;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= roll_rnd;
            pitch_reg <= pitch_rnd;
            yaw_reg   <= yaw_rnd;
        end
    end

`ifndef SYNTH
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg[ROOT_BITS-1] |->
        !(sq_root_reg[ROOT_BITS-1][ROOT_BITS-1] && (sq_root_reg[ROOT_BITS-1][ROOT_BITS-2:0] != '0)))
        else $error("pitch cosine above one");
    a_clamp_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cd_vld_reg[LAST] && cd_flag_reg[LAST][1])
        |=> (pitch_angle == (ANGLE_BITS'(1) << (ANGLE_BITS - 2))))
        else $error("positive pitch clamp lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler
// unit quaternion to zyx roll, pitch and yaw binary angles
// ----------------------------------------------------------------------------
// takes one quaternion transfer per cycle unless back-pressure stalls it and
// returns one angle transfer per quaternion, in order. a transfer passes 3
// front stages, 1 queue stage, 31 square-root stages, 30 cordic stages and 1
// output register; the square-root stages are the 31-bit pipelined square
// root of the pitch cosine, the cordic stages the 30-step cordic lanes that run
// side by side for the three angles. the whole back pipeline holds while a
// result waits at the output; the two-entry queue takes front transfers till full.
module quaternion_to_euler #(
    parameter int COMP_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // comp_w, comp_x, comp_y, comp_z
    input  logic [((4*COMP_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // roll_angle, pitch_angle, yaw_angle
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]       m_tdata
);
    import q2e_pkg::*;

    logic                  f_valid, f_ready, b_valid, b_ready;
    q2e_job_t              f_job, b_job;
    logic [ANGLE_BITS-1:0] roll_angle, pitch_angle, yaw_angle;

    q2e_front #(
        .COMP_BITS (COMP_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .comp_w    ($signed(s_tdata[COMP_BITS-1:0])),
        .comp_x    ($signed(s_tdata[2*COMP_BITS-1:COMP_BITS])),
        .comp_y    ($signed(s_tdata[3*COMP_BITS-1:2*COMP_BITS])),
        .comp_z    ($signed(s_tdata[4*COMP_BITS-1:3*COMP_BITS])),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_job   (f_job)
    );

    q2e_queue #(
        .WIDTH ($bits(q2e_job_t)),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_job),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_job)
    );

    q2e_back #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (b_valid),
        .in_ready    (b_ready),
        .in_job      (b_job),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

    always_comb
    begin
        m_tdata = '0;
        m_tdata[ANGLE_BITS-1:0]              = roll_angle;
        m_tdata[2*ANGLE_BITS-1:ANGLE_BITS]   = pitch_angle;
        m_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS] = yaw_angle;
    end

endmodule
`default_nettype wire
